// ----- sv/batched_matrix_multiply_defines.svh -----
// Assertion macros shared by the batched matrix multiply RTL.
`ifndef BATCHED_MATRIX_MULTIPLY_DEFINES_SVH
`define BATCHED_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent.
`define BMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmm same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmm next-cycle check failed");

`else

`define BMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/bmm_pkg.sv -----
// Shared constants, types and helper functions of the batched matrix multiply.
package bmm_pkg;

  localparam int unsigned MAX_DIM     = 16;
  localparam int unsigned DIM_AW      = $clog2(MAX_DIM);
  localparam int unsigned DIM_CW      = $clog2(MAX_DIM + 1);
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned PROD_W      = 2 * VALUE_W;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned ROWCOL_W    = 4;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned COUNT_MAX   = 256;
  localparam int unsigned DIM_REG_W   = 5;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH_COUNT   = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_ROWS_M        = 3'd2,
    CFG_INNER_K       = 3'd3,
    CFG_COLS_N        = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD_RIGHT  = 1'b0,
    OP_STREAM_LEFT = 1'b1
  } op_e;

  typedef struct packed {
    logic                      opcode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] product;
    logic [IDX_W-1:0]        batch_index;
    logic [IDX_W-1:0]        channel_index;
    logic [ROWCOL_W-1:0]     row_index;
    logic [ROWCOL_W-1:0]     col_index;
    logic                    last;
  } out_word_t;

  // One column step of a left element, with the tags its result needs
  typedef struct packed {
    logic                      valid;
    logic [DIM_AW-1:0]         col;
    logic                      last;
    logic                      emit;
    logic signed [VALUE_W-1:0] a;
    logic [DIM_AW-1:0]         row;
    logic [IDX_W-1:0]          channel;
    logic [IDX_W-1:0]          batch;
  } issue_t;

  typedef struct packed {
    logic              en;
    logic [DIM_AW-1:0] addr;
    logic [SUM_W-1:0]  data;
  } sum_wr_t;

  typedef struct packed {
    logic busy;
    logic adv;
  } mac_status_t;

  // Map a dimension register onto 1..MAX_DIM
  function automatic logic [DIM_CW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [DIM_CW-1:0] r;
    if (v == '0) begin
      r = DIM_CW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_CW'(MAX_DIM);
    end else begin
      r = DIM_CW'(v);
    end
    return r;
  endfunction

  // Map a count register onto 1..COUNT_MAX
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (32'(v) > COUNT_MAX) begin
      r = COUNT_W'(COUNT_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/bmm_if.sv -----
// Valid/ready stream interfaces for the input and result words.
interface bmm_in_if import bmm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmm_out_if import bmm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/batched_matrix_multiply.sv -----
// Top level of the batched matrix multiply: registers, slice counters, column sequencer.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    opcode, value (Q8.8)
//   out_o    out  valid/ready    product (Q20.16), batch/channel/row/col index, last
//   cfg      in   cfg_we_i only  cfg_index_i, cfg_data_i
//
// A right-matrix load is written into the store as it is accepted. A left element is
// accepted, then stepped through its n columns via the single multiplier and the
// row-sum store, then held in the wait state until the pipeline drains before the next word.
// Reset leaves the sums reading zero through valid bits; no clearing pass.
// A stalled result word freezes the pipeline; input waits until the sequencer idles.
`include "batched_matrix_multiply_defines.svh"

module batched_matrix_multiply import bmm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bmm_in_if.sink                in_i,
  bmm_out_if.source             out_o
);

  localparam int unsigned KN_W   = 2 * DIM_CW;
  localparam int unsigned WIDE_W = DIM_AW + DIM_CW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_e;

  logic [COUNT_W-1:0]        batch_count_q;
  logic [COUNT_W-1:0]        channel_count_q;
  logic [DIM_REG_W-1:0]      rows_m_q;
  logic [DIM_REG_W-1:0]      inner_k_q;
  logic [DIM_REG_W-1:0]      cols_n_q;

  logic [DIM_CW-1:0]         m_c;
  logic [DIM_CW-1:0]         k_c;
  logic [DIM_CW-1:0]         n_c;
  logic [COUNT_W-1:0]        bc_c;
  logic [COUNT_W-1:0]        cc_c;
  logic [KN_W-1:0]           kn;

  logic [STORE_AW-1:0]       wpos_q;
  logic [STORE_AW-1:0]       wpos_d;
  logic [STORE_AW-1:0]       pos_eff;
  logic [KN_W-1:0]           pos_inc;
  logic [DIM_AW-1:0]         left_col_q;
  logic [DIM_AW-1:0]         left_col_d;
  logic [DIM_AW-1:0]         left_row_q;
  logic [DIM_AW-1:0]         left_row_d;
  logic [IDX_W-1:0]          channel_q;
  logic [IDX_W-1:0]          channel_d;
  logic [IDX_W-1:0]          batch_q;
  logic [IDX_W-1:0]          batch_d;
  logic [DIM_CW-1:0]         col_inc;
  logic [DIM_CW-1:0]         row_inc;
  logic [COUNT_W-1:0]        ch_inc;
  logic [COUNT_W-1:0]        bt_inc;
  logic                      row_done;

  state_e                    state_q;
  state_e                    state_d;
  logic [DIM_AW-1:0]         j_q;
  logic [DIM_AW-1:0]         j_d;
  logic                      j_last;
  logic signed [VALUE_W-1:0] item_a_q;
  logic [DIM_AW-1:0]         item_col_q;
  logic                      item_emit_q;
  logic [DIM_AW-1:0]         item_row_q;
  logic [IDX_W-1:0]          item_channel_q;
  logic [IDX_W-1:0]          item_batch_q;

  logic                      in_fire;
  logic                      load_fire;
  logic                      stream_fire;
  logic                      issue_fire;
  logic [WIDE_W-1:0]         b_addr_wide;
  issue_t                    issue;
  logic [VALUE_W-1:0]        b_data;
  logic [SUM_W-1:0]          sum_data;
  sum_wr_t                   sum_wr;
  mac_status_t               mac_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_count_q   <= COUNT_W'(1);
      channel_count_q <= COUNT_W'(1);
      rows_m_q        <= DIM_REG_W'(1);
      inner_k_q       <= DIM_REG_W'(1);
      cols_n_q        <= DIM_REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BATCH_COUNT:   batch_count_q   <= COUNT_W'(cfg_data_i);
        CFG_CHANNEL_COUNT: channel_count_q <= COUNT_W'(cfg_data_i);
        CFG_ROWS_M:        rows_m_q        <= cfg_data_i[DIM_REG_W-1:0];
        CFG_INNER_K:       inner_k_q       <= cfg_data_i[DIM_REG_W-1:0];
        CFG_COLS_N:        cols_n_q        <= cfg_data_i[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_c  = clamp_dim(rows_m_q);
  assign k_c  = clamp_dim(inner_k_q);
  assign n_c  = clamp_dim(cols_n_q);
  assign bc_c = clamp_count(batch_count_q);
  assign cc_c = clamp_count(channel_count_q);
  assign kn   = KN_W'(k_c) * KN_W'(n_c);

  // Handshake
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign load_fire   = in_fire && (in_i.data.opcode == OP_LOAD_RIGHT);
  assign stream_fire = in_fire && (in_i.data.opcode == OP_STREAM_LEFT);
  assign issue_fire  = (state_q == S_ISSUE) && mac_status.adv;

  // Right-matrix write position, wrapped at k*n
  always_comb begin
    pos_eff = (KN_W'(wpos_q) >= kn) ? '0 : wpos_q;
    pos_inc = KN_W'(pos_eff) + KN_W'(1);
    wpos_d  = (pos_inc >= kn) ? '0 : pos_inc[STORE_AW-1:0];
  end

  // Slice counters: column, row, channel, batch
  always_comb begin
    col_inc    = DIM_CW'(left_col_q) + DIM_CW'(1);
    row_inc    = DIM_CW'(left_row_q) + DIM_CW'(1);
    ch_inc     = COUNT_W'(channel_q) + COUNT_W'(1);
    bt_inc     = COUNT_W'(batch_q) + COUNT_W'(1);
    row_done   = (col_inc >= k_c);
    left_col_d = col_inc[DIM_AW-1:0];
    left_row_d = left_row_q;
    channel_d  = channel_q;
    batch_d    = batch_q;
    if (row_done) begin
      left_col_d = '0;
      left_row_d = row_inc[DIM_AW-1:0];
      if (row_inc >= m_c) begin
        left_row_d = '0;
        channel_d  = ch_inc[IDX_W-1:0];
        if (ch_inc >= cc_c) begin
          channel_d = '0;
          batch_d   = (bt_inc >= bc_c) ? '0 : bt_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      left_col_q <= '0;
      left_row_q <= '0;
      channel_q  <= '0;
      batch_q    <= '0;
    end else begin
      if (load_fire) begin
        wpos_q <= wpos_d;
      end
      if (stream_fire) begin
        left_col_q <= left_col_d;
        left_row_q <= left_row_d;
        channel_q  <= channel_d;
        batch_q    <= batch_d;
      end
    end
  end

  // Capture the left element and the tags of its row
  always_ff @(posedge clk_i) begin
    if (stream_fire) begin
      item_a_q       <= in_i.data.value;
      item_col_q     <= left_col_q;
      item_emit_q    <= row_done;
      item_row_q     <= left_row_q;
      item_channel_q <= channel_q;
      item_batch_q   <= batch_q;
    end
  end

  // Column sequencer
  assign j_last = ((DIM_CW'(j_q) + DIM_CW'(1)) >= n_c);

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    case (state_q)
      S_IDLE: begin
        if (stream_fire) begin
          state_d = S_ISSUE;
          j_d     = '0;
        end
      end
      S_ISSUE: begin
        if (issue_fire) begin
          if (j_last) begin
            state_d = S_WAIT;
          end else begin
            j_d = j_q + DIM_AW'(1);
          end
        end
      end
      S_WAIT: begin
        if (!mac_status.busy) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
    end
  end

  // Column step: right entry at (col, j), tags for the pipeline
  assign b_addr_wide = WIDE_W'(item_col_q) * WIDE_W'(n_c) + WIDE_W'(j_q);

  always_comb begin
    issue.valid   = issue_fire;
    issue.col     = j_q;
    issue.last    = j_last;
    issue.emit    = item_emit_q;
    issue.a       = item_a_q;
    issue.row     = item_row_q;
    issue.channel = item_channel_q;
    issue.batch   = item_batch_q;
  end

  bmm_right_mem u_right_mem (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (pos_eff),
    .wdata_i (in_i.data.value),
    .re_i    (issue_fire),
    .raddr_i (b_addr_wide[STORE_AW-1:0]),
    .rdata_o (b_data)
  );

  bmm_sum_mem u_sum_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (sum_wr),
    .re_i    (issue_fire),
    .raddr_i (j_q),
    .rdata_o (sum_data)
  );

  bmm_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .b_data_i   (b_data),
    .sum_data_i (sum_data),
    .sum_wr_o   (sum_wr),
    .status_o   (mac_status),
    .out_o      (out_o)
  );

  // Input is only taken with the pipeline empty, so row-sum accesses never overlap
  `BMM_ASSERT_IMPLY(a_ready_when_drained, clk_i, rst_ni, in_i.ready, !mac_status.busy)
  `BMM_ASSERT_IMPLY(a_issue_col_in_range, clk_i, rst_ni, issue_fire, DIM_CW'(j_q) < n_c)
  `BMM_ASSERT_NEXT(a_last_step_waits, clk_i, rst_ni, issue_fire && j_last, state_q == S_WAIT)

endmodule

// ----- sv/bmm_right_mem.sv -----
// Right-matrix store: one write port, one registered read port.
module bmm_right_mem import bmm_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [STORE_AW-1:0] waddr_i,
  input  logic [VALUE_W-1:0]  wdata_i,
  input  logic                re_i,
  input  logic [STORE_AW-1:0] raddr_i,
  output logic [VALUE_W-1:0]  rdata_o
);

  logic [VALUE_W-1:0] mem [STORE_DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  // Write on load, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bmm_sum_mem.sv -----
// Row-sum store with per-entry valid bits so that reset reads as zero.
module bmm_sum_mem import bmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sum_wr_t           wr_i,
  input  logic              re_i,
  input  logic [DIM_AW-1:0] raddr_i,
  output logic [SUM_W-1:0]  rdata_o
);

  logic [SUM_W-1:0]   mem [MAX_DIM];
  logic [MAX_DIM-1:0] valid_q;
  logic [SUM_W-1:0]   rdata_q;
  logic               rvalid_q;

  // Data array: write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Mark entries written, track validity of the read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- sv/bmm_mac.sv -----
// Multiply-accumulate pipeline: multiply stage, add/write-back stage, result register.
module bmm_mac import bmm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  issue_t             issue_i,
  input  logic [VALUE_W-1:0] b_data_i,
  input  logic [SUM_W-1:0]   sum_data_i,
  output sum_wr_t            sum_wr_o,
  output mac_status_t        status_o,
  bmm_out_if.source          out_o
);

  logic                     adv;
  logic                     va_q;
  issue_t                   ta_q;
  logic                     vb_q;
  issue_t                   tb_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         sum_q;
  logic signed [SUM_W-1:0]  prod_ext;
  logic [SUM_W-1:0]         sum_new;
  logic                     out_load;
  logic                     out_valid_q;
  out_word_t                out_q;

  // Advance the whole pipeline unless a result word is stuck
  assign adv = !out_valid_q || out_o.ready;

  // Valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv) begin
      va_q <= issue_i.valid;
      vb_q <= va_q;
    end
  end

  // Multiply the left element by the right entry registered when it was issued
  assign prod_d = ta_q.a * $signed(b_data_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q   <= issue_i;
      tb_q   <= ta_q;
      prod_q <= prod_d;
      sum_q  <= sum_data_i;
    end
  end

  // Accumulate; on the row's last element clear the entry and emit the sum
  assign prod_ext = SUM_W'(prod_q);
  assign sum_new  = sum_q + prod_ext;

  always_comb begin
    sum_wr_o.en   = vb_q && adv;
    sum_wr_o.addr = tb_q.col;
    sum_wr_o.data = tb_q.emit ? '0 : sum_new;
  end

  assign out_load = vb_q && adv && tb_q.emit;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.product       <= sum_new;
      out_q.batch_index   <= tb_q.batch;
      out_q.channel_index <= tb_q.channel;
      out_q.row_index     <= ROWCOL_W'(tb_q.row);
      out_q.col_index     <= ROWCOL_W'(tb_q.col);
      out_q.last          <= tb_q.last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign status_o.busy = va_q || vb_q;
  assign status_o.adv  = adv;

endmodule
